[hdl/kau_pkg.sv]
`default_nettype none

package kau_pkg;

   // Default geometry
   localparam int KAU_MAX_CLUSTERS = 16;
   localparam int KAU_DIMS         = 4;

   // Field and store widths
   localparam int KAU_IDX_W   = 6;   // holds any cluster index up to 64 clusters
   localparam int KAU_DIM_W   = 2;   // holds any dimension index for up to 4 dimensions
   localparam int KAU_PORTS   = 4;   // coordinate ports on the input channel
   localparam int KAU_COORD_W = 16;
   localparam int KAU_SUM_W   = 40;
   localparam int KAU_CNT_W   = 24;
   localparam int KAU_K_W     = 5;
   localparam int KAU_QUO_W   = 17;
   localparam int KAU_NUM_W   = KAU_SUM_W + 2;
   localparam int KAU_DEN_W   = KAU_CNT_W + 1;
   localparam int KAU_SQ_W    = 33;
   localparam int KAU_DIST_W  = 35;

   localparam logic [KAU_K_W-1:0]   KAU_K_RESET   = 5'd16;
   localparam logic [KAU_CNT_W-1:0] KAU_COUNT_MAX = 24'hFF_FFFF;

   // Spare code: changes nothing and returns a zero result
   typedef enum logic [1:0] {
      ACT_LOAD     = 2'd0,
      ACT_CLASSIFY = 2'd1,
      ACT_END_PASS = 2'd2,
      ACT_NONE     = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_SCAN_WAIT,
      ST_UPD_READ,
      ST_UPD_WRITE,
      ST_EP_READ,
      ST_EP_CHECK,
      ST_EP_START,
      ST_EP_DIV,
      ST_EP_WRITE,
      ST_EP_NEXT,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic                 capture;
      logic                 load_mean;
      logic                 scan_issue;
      logic                 sum_read;
      logic                 sum_write;
      logic                 ep_read;
      logic                 div_start;
      logic                 div_store;
      logic                 mean_write;
      logic                 acc_clear;
      logic                 take_pass;
      logic                 finish;
      logic [KAU_IDX_W-1:0] idx;
      logic [KAU_DIM_W-1:0] dim;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic scan_busy;
      logic count_zero;
      logic div_done;
      logic rsp_full;
   } stat_type;

endpackage

`default_nettype wire

[hdl/kmeans_assign_update.sv]
// Lloyd k-means assign and update engine, signed Q1.15 coordinates.
// Input channel req_*: valid/stall, one item per transfer. Action load writes
// one centroid mean, classify returns the nearest of the first k centroids and
// adds the point to its sums, end of pass turns sums into rounded means.
// Result channel rsp_*: valid/stall, exactly one result per input item.
// Configuration channel csr_*: valid/ready, writes k; always ready.
// Classify scans the mean memory one centroid per cycle through a three-stage
// distance pipeline; end of pass walks every cluster and, for each filled one,
// runs the shared bit-serial divider (17 steps per coordinate).
// One item is in work at a time; the next is taken once the result is handed
// to the output register, so a stalled result holds back only the item after.
// Reset sets k to 16, clears the moved flag, and clears all means, sums and
// counts through per-cluster valid bits; no clearing pass is needed.
`default_nettype none

module kmeans_assign_update #(
   parameter int MAX_CLUSTERS = kau_pkg::KAU_MAX_CLUSTERS,
   parameter int DIMS         = kau_pkg::KAU_DIMS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic [3:0]  req_centroid_index,
   input  wire logic [3:0]  req_prior_cluster,
   input  wire logic [15:0] req_coord_0,
   input  wire logic [15:0] req_coord_1,
   input  wire logic [15:0] req_coord_2,
   input  wire logic [15:0] req_coord_3,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_cluster_index,
   output logic             rsp_moved,
   output logic             rsp_pass_changed,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [4:0]  csr_clusters_in_use
);

   kau_pkg::cmd_type  cmd;
   kau_pkg::stat_type stat;

   kau_ctrl #(
      .MAX_CLUSTERS (MAX_CLUSTERS),
      .DIMS         (DIMS)
   ) u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_clusters_in_use (csr_clusters_in_use),
      .stat                (stat),
      .cmd                 (cmd)
   );

   kau_dpath #(
      .MAX_CLUSTERS (MAX_CLUSTERS),
      .DIMS         (DIMS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_centroid_index (req_centroid_index),
      .req_prior_cluster  (req_prior_cluster),
      .req_coord          ({req_coord_3, req_coord_2, req_coord_1, req_coord_0}),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_cluster_index  (rsp_cluster_index),
      .rsp_moved          (rsp_moved),
      .rsp_pass_changed   (rsp_pass_changed)
   );

   // An accepted item keeps the input stalled while it is worked on
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken twice in a row");

   // A new result appears only when the controller hands one over
   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.finish))
      else $error("result raised without a finish command");

   // The accumulator update always follows its read
   a_update_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.sum_write |-> $past(cmd.sum_read))
      else $error("accumulator written without a fresh read");

   // A divider result is stored only once it is done
   a_store_when_done: assert property (@(posedge clock) disable iff (reset)
      cmd.div_store |-> stat.div_done)
      else $error("quotient stored before the divider finished");

endmodule

`default_nettype wire

[hdl/kau_div.sv]
`default_nettype none

module kau_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [kau_pkg::KAU_NUM_W-1:0]  num,
   input  wire logic [kau_pkg::KAU_DEN_W-1:0]  den,
   output logic                                done,
   output logic [kau_pkg::KAU_QUO_W-1:0]       quo
);

   localparam int QW = kau_pkg::KAU_QUO_W;
   localparam int DW = kau_pkg::KAU_DEN_W;
   localparam logic [4:0] LAST_STEP = 5'(QW - 1);

   logic [DW-1:0] rem_ff;
   logic [QW-1:0] low_ff;
   logic [QW-1:0] quo_ff;
   logic [4:0]    step_ff;
   logic          busy_ff;
   logic          done_ff;

   logic [DW:0]   trial;
   logic          fits;

   // One restoring step: shift in the next numerator bit, subtract if it fits
   always_comb begin
      trial = {rem_ff, low_ff[QW-1]};
      fits  = trial >= {1'b0, den};
   end

   // Control: the quotient is known to fit in QW bits, so only QW steps run
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else if (busy_ff) begin
         step_ff <= step_ff + 5'd1;
         if (step_ff == LAST_STEP) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // Remainder and quotient shift registers
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= num[kau_pkg::KAU_NUM_W-1:QW];
         low_ff <= num[QW-1:0];
      end else if (busy_ff) begin
         rem_ff <= fits ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
         low_ff <= {low_ff[QW-2:0], 1'b0};
         quo_ff <= {quo_ff[QW-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

`default_nettype wire

[hdl/kau_ctrl.sv]
`default_nettype none

module kau_ctrl #(
   parameter int MAX_CLUSTERS = kau_pkg::KAU_MAX_CLUSTERS,
   parameter int DIMS         = kau_pkg::KAU_DIMS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [1:0]                   req_action,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [kau_pkg::KAU_K_W-1:0]  csr_clusters_in_use,
   input  wire kau_pkg::stat_type            stat,
   output kau_pkg::cmd_type                  cmd
);

   localparam int CW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
   localparam int DW = (DIMS > 1) ? $clog2(DIMS) : 1;
   localparam logic [6:0]    MAXK     = 7'(MAX_CLUSTERS);
   localparam logic [CW-1:0] IDX_LAST = CW'(MAX_CLUSTERS - 1);
   localparam logic [DW-1:0] DIM_LAST = DW'(DIMS - 1);

   kau_pkg::state_type state_ff, state_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [DW-1:0] dim_ff, dim_in;
   logic [kau_pkg::KAU_K_W-1:0] k_ff;

   logic [6:0]    k_raw;
   logic [6:0]    k_eff;
   logic [CW-1:0] k_last;

   // Cluster count register
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= kau_pkg::KAU_K_RESET;
      end else if (csr_valid && csr_ready) begin
         k_ff <= csr_clusters_in_use;
      end
   end

   assign csr_ready = 1'b1;

   // Clamp k into 1..MAX_CLUSTERS
   always_comb begin
      k_raw = 7'(k_ff);
      if (k_raw == 7'd0) begin
         k_eff = 7'd1;
      end else if (k_raw > MAXK) begin
         k_eff = MAXK;
      end else begin
         k_eff = k_raw;
      end
      k_last = CW'(k_eff - 7'd1);
   end

   // State and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kau_pkg::ST_IDLE;
         idx_ff   <= '0;
         dim_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         dim_ff   <= dim_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      dim_in    = dim_ff;
      cmd       = '0;
      cmd.idx   = kau_pkg::KAU_IDX_W'(idx_ff);
      cmd.dim   = kau_pkg::KAU_DIM_W'(dim_ff);
      req_stall = (state_ff != kau_pkg::ST_IDLE);

      case (state_ff)
         kau_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               idx_in      = '0;
               dim_in      = '0;
               case (req_action)
                  kau_pkg::ACT_LOAD:     state_in = kau_pkg::ST_LOAD;
                  kau_pkg::ACT_CLASSIFY: state_in = kau_pkg::ST_SCAN;
                  kau_pkg::ACT_END_PASS: state_in = kau_pkg::ST_EP_READ;
                  default:               state_in = kau_pkg::ST_FINISH;
               endcase
            end
         end
         kau_pkg::ST_LOAD: begin
            cmd.load_mean = 1'b1;
            state_in      = kau_pkg::ST_FINISH;
         end
         // Issue one centroid per cycle into the distance pipeline
         kau_pkg::ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (idx_ff == k_last) begin
               state_in = kau_pkg::ST_SCAN_WAIT;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         kau_pkg::ST_SCAN_WAIT: begin
            if (!stat.scan_busy) begin
               state_in = kau_pkg::ST_UPD_READ;
            end
         end
         kau_pkg::ST_UPD_READ: begin
            cmd.sum_read = 1'b1;
            state_in     = kau_pkg::ST_UPD_WRITE;
         end
         kau_pkg::ST_UPD_WRITE: begin
            cmd.sum_write = 1'b1;
            state_in      = kau_pkg::ST_FINISH;
         end
         // End of pass: walk every cluster
         kau_pkg::ST_EP_READ: begin
            cmd.ep_read = 1'b1;
            state_in    = kau_pkg::ST_EP_CHECK;
         end
         kau_pkg::ST_EP_CHECK: begin
            dim_in = '0;
            if (stat.count_zero) begin
               state_in = kau_pkg::ST_EP_NEXT;
            end else begin
               state_in = kau_pkg::ST_EP_START;
            end
         end
         kau_pkg::ST_EP_START: begin
            cmd.div_start = 1'b1;
            state_in      = kau_pkg::ST_EP_DIV;
         end
         kau_pkg::ST_EP_DIV: begin
            if (stat.div_done) begin
               cmd.div_store = 1'b1;
               if (dim_ff == DIM_LAST) begin
                  state_in = kau_pkg::ST_EP_WRITE;
               end else begin
                  dim_in   = dim_ff + DW'(1);
                  state_in = kau_pkg::ST_EP_START;
               end
            end
         end
         kau_pkg::ST_EP_WRITE: begin
            cmd.mean_write = 1'b1;
            state_in       = kau_pkg::ST_EP_NEXT;
         end
         kau_pkg::ST_EP_NEXT: begin
            cmd.acc_clear = 1'b1;
            if (idx_ff == IDX_LAST) begin
               cmd.take_pass = 1'b1;
               state_in      = kau_pkg::ST_FINISH;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = kau_pkg::ST_EP_READ;
            end
         end
         // Hand the result to the output register once it is free
         kau_pkg::ST_FINISH: begin
            if (!stat.rsp_full) begin
               cmd.finish = 1'b1;
               state_in   = kau_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kau_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[hdl/kau_dpath.sv]
`default_nettype none

module kau_dpath #(
   parameter int MAX_CLUSTERS = kau_pkg::KAU_MAX_CLUSTERS,
   parameter int DIMS         = kau_pkg::KAU_DIMS
) (
   input  wire logic                                           clock,
   input  wire logic                                           reset,
   input  wire kau_pkg::cmd_type                               cmd,
   output kau_pkg::stat_type                                   stat,
   input  wire logic [3:0]                                     req_centroid_index,
   input  wire logic [3:0]                                     req_prior_cluster,
   input  wire logic [kau_pkg::KAU_PORTS-1:0][kau_pkg::KAU_COORD_W-1:0] req_coord,
   output logic                                                rsp_valid,
   input  wire logic                                           rsp_stall,
   output logic [3:0]                                          rsp_cluster_index,
   output logic                                                rsp_moved,
   output logic                                                rsp_pass_changed
);

   localparam int CW  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
   localparam int DW  = (DIMS > 1) ? $clog2(DIMS) : 1;
   localparam int XW  = kau_pkg::KAU_COORD_W;
   localparam int SW  = kau_pkg::KAU_SUM_W;
   localparam int NW  = kau_pkg::KAU_CNT_W;
   localparam int IW  = kau_pkg::KAU_IDX_W;
   localparam logic [6:0] MAXK = 7'(MAX_CLUSTERS);

   // Latched item
   logic signed [XW-1:0] pt_ff [DIMS];
   logic [3:0]           prior_ff;
   logic [3:0]           cidx_ff;

   // Result being built and output register
   logic [3:0] res_idx_ff;
   logic       res_moved_ff;
   logic       res_pc_ff;
   logic       any_moved_ff;
   logic       rsp_valid_ff;
   logic [3:0] rsp_idx_ff;
   logic       rsp_moved_ff;
   logic       rsp_pc_ff;

   // Mean store
   logic [DIMS*XW-1:0]     means_mem [MAX_CLUSTERS];
   logic [MAX_CLUSTERS-1:0] mean_vld_ff;
   logic [DIMS*XW-1:0]     pt_row;
   logic [DIMS*XW-1:0]     new_row;
   logic [XW-1:0]          new_ff [DIMS];
   logic                   ld_ok;
   logic [CW-1:0]          ld_addr;
   logic [CW-1:0]          mw_addr;
   logic [DIMS*XW-1:0]     mw_data;
   logic                   mw_en;
   logic [CW-1:0]          c_addr;

   // Distance pipeline
   logic                          v1_ff, v2_ff;
   logic [CW-1:0]                 idx1_ff, idx2_ff;
   logic                          mvld1_ff;
   logic [DIMS*XW-1:0]            mean_rd_ff;
   logic [kau_pkg::KAU_SQ_W-1:0]  sq_in [DIMS];
   logic [kau_pkg::KAU_SQ_W-1:0]  sq_ff [DIMS];
   logic [kau_pkg::KAU_DIST_W-1:0] cand_dist;
   logic [kau_pkg::KAU_DIST_W-1:0] best_dist_ff;
   logic [CW-1:0]                 best_ff;

   // Accumulator store
   logic [DIMS*SW-1:0]      sums_mem [MAX_CLUSTERS];
   logic [NW-1:0]           cnt_mem [MAX_CLUSTERS];
   logic [MAX_CLUSTERS-1:0] acc_vld_ff;
   logic [DIMS*SW-1:0]      sum_rd_ff;
   logic [NW-1:0]           cnt_rd_ff;
   logic                    avld_rd_ff;
   logic [CW-1:0]           acc_raddr;
   logic [DIMS*SW-1:0]      sum_eff;
   logic [NW-1:0]           cnt_eff;
   logic [DIMS*SW-1:0]      sum_new;
   logic                    add_ok;
   logic [IW-1:0]           best_wide;
   logic                    moved;

   // Divider operands
   logic [DW-1:0]                  dsel;
   logic signed [SW-1:0]           sel_sum;
   logic                           sel_neg;
   logic [SW-1:0]                  sel_mag;
   logic [kau_pkg::KAU_NUM_W-1:0]  div_num;
   logic [kau_pkg::KAU_DEN_W-1:0]  div_den;
   logic                           div_done;
   logic [kau_pkg::KAU_QUO_W-1:0]  div_quo;
   logic                           sign_ff;
   logic [XW-1:0]                  q16;

   assign c_addr = cmd.idx[CW-1:0];
   assign dsel   = cmd.dim[DW-1:0];

   // Latch the item on transfer
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         for (int d = 0; d < DIMS; d++) begin
            pt_ff[d] <= req_coord[d];
         end
         prior_ff <= req_prior_cluster;
         cidx_ff  <= req_centroid_index;
      end
   end

   // Mean store write port: loads and end-of-pass results
   always_comb begin
      for (int d = 0; d < DIMS; d++) begin
         pt_row[d*XW +: XW]  = pt_ff[d];
         new_row[d*XW +: XW] = new_ff[d];
      end
      ld_ok   = 7'(cidx_ff) < MAXK;
      ld_addr = CW'(IW'(cidx_ff));
      mw_en   = (cmd.load_mean && ld_ok) || cmd.mean_write;
      mw_addr = cmd.load_mean ? ld_addr : c_addr;
      mw_data = cmd.load_mean ? pt_row : new_row;
   end

   always_ff @(posedge clock) begin
      if (mw_en) begin
         means_mem[mw_addr] <= mw_data;
      end
      if (cmd.scan_issue) begin
         mean_rd_ff <= means_mem[c_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_vld_ff <= '0;
      end else if (mw_en) begin
         mean_vld_ff[mw_addr] <= 1'b1;
      end
   end

   // Stage one: mean row read
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.scan_issue;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx1_ff  <= c_addr;
      mvld1_ff <= mean_vld_ff[c_addr];
      idx2_ff  <= idx1_ff;
   end

   // Stage two: squared difference per dimension
   always_comb begin
      for (int d = 0; d < DIMS; d++) begin
         logic signed [XW:0]     diff;
         logic signed [2*XW+1:0] prod;
         logic signed [XW-1:0]   mv;
         mv    = mvld1_ff ? mean_rd_ff[d*XW +: XW] : '0;
         diff  = (XW+1)'(mv) - (XW+1)'(pt_ff[d]);
         prod  = diff * diff;
         sq_in[d] = prod[kau_pkg::KAU_SQ_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      for (int d = 0; d < DIMS; d++) begin
         sq_ff[d] <= sq_in[d];
      end
   end

   // Stage three: total distance and running minimum, lowest index wins ties
   always_comb begin
      cand_dist = '0;
      for (int d = 0; d < DIMS; d++) begin
         cand_dist = cand_dist + kau_pkg::KAU_DIST_W'(sq_ff[d]);
      end
   end

   always_ff @(posedge clock) begin
      if (v2_ff && ((idx2_ff == '0) || (cand_dist < best_dist_ff))) begin
         best_ff      <= idx2_ff;
         best_dist_ff <= cand_dist;
      end
   end

   // Accumulator read port
   assign acc_raddr = cmd.sum_read ? best_ff : c_addr;

   always_ff @(posedge clock) begin
      if (cmd.sum_read || cmd.ep_read) begin
         sum_rd_ff  <= sums_mem[acc_raddr];
         cnt_rd_ff  <= cnt_mem[acc_raddr];
         avld_rd_ff <= acc_vld_ff[acc_raddr];
      end
   end

   // Add the point into the winner's sums unless its count is full
   always_comb begin
      sum_eff = avld_rd_ff ? sum_rd_ff : '0;
      cnt_eff = avld_rd_ff ? cnt_rd_ff : '0;
      add_ok  = cnt_eff != kau_pkg::KAU_COUNT_MAX;
      for (int d = 0; d < DIMS; d++) begin
         sum_new[d*SW +: SW] = sum_eff[d*SW +: SW] + SW'(pt_ff[d]);
      end
      best_wide = IW'(best_ff);
      moved     = best_wide != IW'(prior_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.sum_write && add_ok) begin
         sums_mem[best_ff] <= sum_new;
         cnt_mem[best_ff]  <= cnt_eff + NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_vld_ff <= '0;
      end else if (cmd.sum_write && add_ok) begin
         acc_vld_ff[best_ff] <= 1'b1;
      end else if (cmd.acc_clear) begin
         acc_vld_ff[c_addr] <= 1'b0;
      end
   end

   // Divider operands: rounded |sum| / n is (2|sum| + n) / 2n
   always_comb begin
      sel_sum = sum_eff[dsel*SW +: SW];
      sel_neg = sel_sum[SW-1];
      sel_mag = sel_neg ? SW'(-sel_sum) : SW'(sel_sum);
      div_num = {1'b0, sel_mag, 1'b0} + kau_pkg::KAU_NUM_W'(cnt_eff);
      div_den = {cnt_eff, 1'b0};
      q16     = div_quo[XW-1:0];
   end

   kau_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         sign_ff <= sel_neg;
      end
      if (cmd.div_store) begin
         new_ff[dsel] <= sign_ff ? XW'(-q16) : q16;
      end
   end

   // Result fields and pass flag
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         res_idx_ff   <= '0;
         res_moved_ff <= 1'b0;
         res_pc_ff    <= 1'b0;
      end else if (cmd.sum_write) begin
         res_idx_ff   <= best_wide[3:0];
         res_moved_ff <= moved;
      end else if (cmd.take_pass) begin
         res_pc_ff <= any_moved_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         any_moved_ff <= 1'b0;
      end else if (cmd.take_pass) begin
         any_moved_ff <= 1'b0;
      end else if (cmd.sum_write && moved) begin
         any_moved_ff <= 1'b1;
      end
   end

   // Output register: hold while stalled, drop once transferred
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_idx_ff   <= res_idx_ff;
         rsp_moved_ff <= res_moved_ff;
         rsp_pc_ff    <= res_pc_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cluster_index = rsp_idx_ff;
   assign rsp_moved         = rsp_moved_ff;
   assign rsp_pass_changed  = rsp_pc_ff;

   always_comb begin
      stat.scan_busy  = v1_ff || v2_ff;
      stat.count_zero = !avld_rd_ff || (cnt_rd_ff == '0);
      stat.div_done   = div_done;
      stat.rsp_full   = rsp_valid_ff && rsp_stall;
   end

endmodule

`default_nettype wire

[dv/kmeans_checker.sv]
`timescale 1ns / 100ps
`default_nettype none

module kmeans_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic [3:0]  req_centroid_index,
   input  wire logic [3:0]  req_prior_cluster,
   input  wire logic [15:0] req_coord_0,
   input  wire logic [15:0] req_coord_1,
   input  wire logic [15:0] req_coord_2,
   input  wire logic [15:0] req_coord_3,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [3:0]  rsp_cluster_index,
   input  wire logic        rsp_moved,
   input  wire logic        rsp_pass_changed,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [4:0]  csr_clusters_in_use,
   output int               failures,
   output int               pending
);

   typedef struct packed {
      logic [3:0] cluster;
      logic       moved;
      logic       pass_changed;
   } verdict_type;

   verdict_type       verdicts[$];
   logic [4:0]        k_reg;
   logic signed [15:0] means[16][4];
   logic signed [39:0] sums[16][4];
   logic [23:0]       counts[16];
   logic              moved_flag;

   assign pending = verdicts.size();

   task automatic report(input string what, input int got, input int want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      failures++;
   endtask

   function automatic logic signed [15:0] round_mean(input logic signed [39:0] s,
                                                      input logic [23:0] n);
      logic [40:0] mag;
      logic [41:0] q;
      mag = s < 0 ? -s : s;
      q = (2 * {1'b0, mag} + n) / (2 * {18'd0, n});
      return s < 0 ? -q[15:0] : q[15:0];
   endfunction

   // Work out the result of one transfer and advance the model state
   task automatic predict_item(input logic [1:0] act, input logic [3:0] cidx,
                               input logic [3:0] prior, input logic signed [15:0] pt[4]);
      verdict_type v;
      int k, best;
      longint cand_dist, best_dist, diff;
      v = '0;
      case (act)
         kau_pkg::ACT_LOAD: begin
            for (int d = 0; d < 4; d++) means[cidx][d] = pt[d];
         end
         kau_pkg::ACT_CLASSIFY: begin
            k = k_reg == 0 ? 1 : (k_reg > 16 ? 16 : k_reg);
            best = 0;
            best_dist = 0;
            for (int c = 0; c < k; c++) begin
               cand_dist = 0;
               for (int d = 0; d < 4; d++) begin
                  diff = longint'(means[c][d]) - longint'(pt[d]);
                  cand_dist += diff * diff;
               end
               if (c == 0 || cand_dist < best_dist) begin
                  best_dist = cand_dist;
                  best = c;
               end
            end
            if (best != prior) moved_flag = 1;
            if (counts[best] != kau_pkg::KAU_COUNT_MAX) begin
               for (int d = 0; d < 4; d++) sums[best][d] += pt[d];
               counts[best]++;
            end
            v.cluster = 4'(best);
            v.moved = best != prior;
         end
         kau_pkg::ACT_END_PASS: begin
            for (int c = 0; c < 16; c++) begin
               if (counts[c] != 0)
                  for (int d = 0; d < 4; d++) means[c][d] = round_mean(sums[c][d], counts[c]);
               counts[c] = 0;
               for (int d = 0; d < 4; d++) sums[c][d] = 0;
            end
            v.pass_changed = moved_flag;
            moved_flag = 0;
         end
         default: ;
      endcase
      verdicts = {verdicts, v};
   endtask

   // Watch all three channels
   always @(posedge clock) begin
      logic signed [15:0] pt[4];
      verdict_type want;
      if (reset) begin
         k_reg = kau_pkg::KAU_K_RESET;
         moved_flag = 0;
         for (int c = 0; c < 16; c++) begin
            counts[c] = 0;
            for (int d = 0; d < 4; d++) begin
               means[c][d] = 0;
               sums[c][d] = 0;
            end
         end
         verdicts.delete();
      end else begin
         if (csr_valid && csr_ready) k_reg = csr_clusters_in_use;
         if (rsp_valid && !rsp_stall) begin
            if (verdicts.size() == 0) begin
               report("unexpected transfer", rsp_cluster_index, 0);
            end else begin
               want = verdicts.pop_front();
               if (rsp_cluster_index !== want.cluster)
                  report("cluster_index", rsp_cluster_index, want.cluster);
               if (rsp_moved !== want.moved) report("moved", rsp_moved, want.moved);
               if (rsp_pass_changed !== want.pass_changed)
                  report("pass_changed", rsp_pass_changed, want.pass_changed);
            end
         end
         if (req_valid && !req_stall) begin
            pt[0] = req_coord_0;
            pt[1] = req_coord_1;
            pt[2] = req_coord_2;
            pt[3] = req_coord_3;
            predict_item(req_action, req_centroid_index, req_prior_cluster, pt);
         end
      end
   end

   initial failures = 0;
endmodule

`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 100ps
`default_nettype none

module testbench;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_action = 0;
   logic [3:0]  req_centroid_index = 0;
   logic [3:0]  req_prior_cluster = 0;
   logic [15:0] req_coord_0 = 0, req_coord_1 = 0, req_coord_2 = 0, req_coord_3 = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [3:0]  rsp_cluster_index;
   logic        rsp_moved, rsp_pass_changed;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [4:0]  csr_clusters_in_use = 0;
   int          failures, pending;
   logic        drain_done = 0;
   logic [15:0] anchor[4];

   kmeans_assign_update dut (.*);
   kmeans_checker checker_i (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #400ms;
      $display("CHECK FAILED");
      $finish;
   end

   // Receiver stall: fresh random hold for each transfer, with quiet stretches
   initial begin
      int hold;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (hold != 0) rsp_stall <= 1;
         end else if (rsp_stall) begin
            if (hold > 0) hold--;
            if (hold == 0) rsp_stall <= 0;
         end
      end
   end

   // Valid stays high into a back-to-back item and drops only before a gap
   task automatic send(input logic [1:0] act, input logic [3:0] cidx, input logic [3:0] prior,
                       input logic [15:0] c0, c1, c2, c3, input int gap);
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_action <= act;
      req_centroid_index <= cidx;
      req_prior_cluster <= prior;
      req_coord_0 <= c0;
      req_coord_1 <= c1;
      req_coord_2 <= c2;
      req_coord_3 <= c3;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and hold off until every outstanding result has come back
   task automatic hold_until_empty();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic wait_drained();
      hold_until_empty();
      repeat (400) @(posedge clock);
   endtask

   task automatic write_k(input logic [4:0] k);
      csr_valid <= 1;
      csr_clusters_in_use <= k;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
   endtask

   function automatic logic [15:0] near(input logic [15:0] base);
      return base + 16'($signed($urandom_range(0, 4000)) - 2000);
   endfunction

   function automatic int gap_draw();
      return ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 17));
   endfunction

   initial begin
      logic [4:0] k_list[6] = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd7, 5'd3};
      logic [15:0] c[4];
      int r;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: extremes, ties, unknown action
      send(kau_pkg::ACT_LOAD, 0, 0, 16'h7FFF, 16'h8000, 0, 0, 0);
      send(kau_pkg::ACT_LOAD, 1, 0, 16'h8000, 16'h7FFF, 16'hFFFF, 1, 0);
      send(kau_pkg::ACT_LOAD, 15, 0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
      send(kau_pkg::ACT_CLASSIFY, 0, 15, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0);
      send(kau_pkg::ACT_CLASSIFY, 0, 15, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
      send(kau_pkg::ACT_CLASSIFY, 0, 2, 0, 0, 0, 0, 0);
      send(kau_pkg::ACT_CLASSIFY, 0, 0, 16'h7FFF, 16'h8000, 0, 0, 0);
      send(kau_pkg::ACT_NONE, 15, 15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
      send(kau_pkg::ACT_END_PASS, 0, 0, 0, 0, 0, 0, 0);
      send(kau_pkg::ACT_END_PASS, 0, 0, 0, 0, 0, 0, 0);
      send(kau_pkg::ACT_CLASSIFY, 0, 0, 16'h0001, 16'hFFFF, 16'h0003, 16'hFFFD, 0);
      send(kau_pkg::ACT_CLASSIFY, 0, 0, 16'h0000, 16'h0000, 16'h0000, 16'hFFFE, 0);
      send(kau_pkg::ACT_END_PASS, 0, 0, 0, 0, 0, 0, 0);
      wait_drained();

      // Random phases over several k settings; pass-structured sequences
      for (int ph = 0; ph < 6; ph++) begin
         write_k(k_list[ph]);
         for (int ci = 0; ci < 16; ci++) begin
            for (int d = 0; d < 4; d++) c[d] = 16'($urandom);
            send(kau_pkg::ACT_LOAD, 4'(ci), 0, c[0], c[1], c[2], c[3], gap_draw());
         end
         for (int it = 0; it < 290; it++) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
               // points clustered around existing random anchors
               if (it % 20 == 0)
                  for (int d = 0; d < 4; d++) anchor[d] = 16'($urandom);
               send(kau_pkg::ACT_CLASSIFY, 0, 4'($urandom), near(anchor[0]),
                    near(anchor[1]), near(anchor[2]), near(anchor[3]), gap_draw());
            end else if (r < 86) begin
               send(kau_pkg::ACT_CLASSIFY, 0, 4'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), gap_draw());
            end else if (r < 93) begin
               send(kau_pkg::ACT_END_PASS, 4'($urandom), 4'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), 16'($urandom), gap_draw());
            end else if (r < 98) begin
               send(kau_pkg::ACT_LOAD, 4'($urandom), 4'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), 16'($urandom), gap_draw());
            end else begin
               send(kau_pkg::ACT_NONE, 4'($urandom), 4'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), 16'($urandom), gap_draw());
            end
            // hold off until everything outstanding has returned
            if (it == 100) hold_until_empty();
         end
         send(kau_pkg::ACT_END_PASS, 0, 0, 0, 0, 0, 0, 0);
         wait_drained();
      end
      drain_done <= 1;
   end

   initial begin
      @(posedge clock);
      while (!drain_done) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

`default_nettype wire
